### rtl/core/olsu_pkg.sv
// Shared types and constants for the ordered list store.
// Used by olsu_cell and ordered_list_store_unit; no dependencies.
package olsu_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 8;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int FUNC_BITS  = 3;
    localparam int KEEP_BITS  = 5;
    localparam int STAT_BITS  = 2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    typedef enum logic [FUNC_BITS-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_INSERT    = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_CONTAINS  = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_KEEP      = 3'd7
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   upd;     // commit the new cell contents
        logic   ins;     // open a gap at the first hit and load the key
        logic   del;     // close the entry at the first hit
        logic   any;     // hit on any valid cell (any cell for ins) regardless of the compare
        value_t key;
    } cell_cmd_t;

endpackage

### rtl/core/ordered_list_store_unit.sv
// Top level of the ordered list store: a chain of olsu_cell instances plus
// occupancy, command decode and the registered result stage. Uses olsu_pkg.
//
// The block keeps a list of up to 16 unsigned 8-bit values, head at position 0,
// in a row of cells that each hold one entry. Every request is one operation
// (func in s_tuser): push at head, sorted insert, pop head, pop tail, remove
// the first equal value, contains, clear, or keep the first keep_count entries.
// All cells compare their entry against the request value at once; a one-bit
// hit chain running from head to tail picks the first matching position, and
// each cell then holds, takes its left neighbor, takes its right neighbor or
// loads the value, so the whole list shifts in the same cycle. A request
// therefore takes effect as it is accepted and its result (head value, count,
// found flag, status) appears in the output register on the next cycle. The
// output register is the only buffer: a new request is taken whenever that
// register is empty or is drained in the same cycle, giving one request per
// cycle while m_tready stays high. Inserts into a full list leave it unchanged
// and report status full; pops on an empty list report status empty.
module ordered_list_store_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] value, [12:8] keep_count, [15:13] zero
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] head_value, [12:8] entry_count,
                                   // [13] found, [15:14] status
);

    localparam int N = olsu_pkg::DEPTH;

    // ---------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------
    olsu_pkg::op_t                         func;
    olsu_pkg::value_t                      value;
    logic [olsu_pkg::KEEP_BITS-1:0]        keep_count;
    logic                                  accept;

    assign func       = olsu_pkg::op_t'(s_tuser);
    assign value      = s_tdata[olsu_pkg::VALUE_BITS-1:0];
    assign keep_count = s_tdata[olsu_pkg::VALUE_BITS +: olsu_pkg::KEEP_BITS];

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    olsu_pkg::count_t   occ_reg, occ_next;
    logic               m_valid_reg;
    olsu_pkg::value_t   head_reg;
    olsu_pkg::count_t   count_reg;
    logic               found_reg;
    olsu_pkg::status_t  status_reg, status_next;

    // Take a request when the result register is free or drains now.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    logic is_empty, is_full;
    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == olsu_pkg::count_t'(N));

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    olsu_pkg::cell_cmd_t cmd;

    always_comb begin
        cmd.key = value;
        cmd.ins = 1'b0;
        cmd.del = 1'b0;
        cmd.any = 1'b0;
        cmd.upd = 1'b0;
        unique case (func)
            olsu_pkg::OP_PUSH_HEAD: begin
                cmd.ins = 1'b1;
                cmd.any = 1'b1;
                cmd.upd = accept && !is_full;
            end
            olsu_pkg::OP_INSERT: begin
                cmd.ins = 1'b1;
                cmd.upd = accept && !is_full;
            end
            olsu_pkg::OP_POP_HEAD: begin
                cmd.del = 1'b1;
                cmd.any = 1'b1;
                cmd.upd = accept;
            end
            olsu_pkg::OP_REMOVE: begin
                cmd.del = 1'b1;
                cmd.upd = accept;
            end
            olsu_pkg::OP_CONTAINS: begin
                // search only: the cells keep their contents
                cmd.del = 1'b1;
            end
            olsu_pkg::OP_POP_TAIL,
            olsu_pkg::OP_CLEAR,
            olsu_pkg::OP_KEEP: begin
                // occupancy-only operations
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    olsu_pkg::value_t cell_val  [N];
    olsu_pkg::value_t cell_next [N];
    logic [N:0]       hit_chain;
    logic             found_any;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        olsu_pkg::value_t left_v, right_v;
        logic             valid_i;

        assign valid_i = (occ_reg > olsu_pkg::count_t'(i));
        if (i == 0) begin : g_head
            assign left_v = value;
        end else begin : g_mid
            assign left_v = cell_val[i-1];
        end
        if (i == N - 1) begin : g_tail
            assign right_v = cell_val[i];
        end else begin : g_body
            assign right_v = cell_val[i+1];
        end

        olsu_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .valid     (valid_i),
            .left_val  (left_v),
            .right_val (right_v),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .val       (cell_val[i]),
            .val_next  (cell_next[i])
        );
    end

    // Only meaningful for remove and contains, where a hit needs a valid entry.
    assign found_any = hit_chain[N];

    // ---------------------------------------------------------------
    // Occupancy and status
    // ---------------------------------------------------------------
    logic found_next;

    always_comb begin
        occ_next    = occ_reg;
        status_next = olsu_pkg::ST_OK;
        found_next  = 1'b0;
        unique case (func)
            olsu_pkg::OP_PUSH_HEAD,
            olsu_pkg::OP_INSERT: begin
                if (is_full) begin
                    status_next = olsu_pkg::ST_FULL;
                end else begin
                    occ_next = occ_reg + olsu_pkg::count_t'(1);
                end
            end
            olsu_pkg::OP_POP_HEAD,
            olsu_pkg::OP_POP_TAIL: begin
                if (is_empty) begin
                    status_next = olsu_pkg::ST_EMPTY;
                end else begin
                    occ_next = occ_reg - olsu_pkg::count_t'(1);
                end
            end
            olsu_pkg::OP_REMOVE,
            olsu_pkg::OP_CONTAINS: begin
                if (is_empty) begin
                    status_next = olsu_pkg::ST_EMPTY;
                end else if (!found_any) begin
                    status_next = olsu_pkg::ST_MISSING;
                end else begin
                    found_next = 1'b1;
                    if (func == olsu_pkg::OP_REMOVE) begin
                        occ_next = occ_reg - olsu_pkg::count_t'(1);
                    end
                end
            end
            olsu_pkg::OP_CLEAR: begin
                occ_next = '0;
            end
            olsu_pkg::OP_KEEP: begin
                // drop the tail beyond keep_count
                if (olsu_pkg::count_t'(keep_count) < occ_reg) begin
                    occ_next = olsu_pkg::count_t'(keep_count);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Occupancy and result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                occ_reg     <= occ_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: head after the update, zero when the list ends up empty.
    // Take the shifted head only when the cells actually commit it.
    always_ff @(posedge aclk) begin
        if (accept) begin
            head_reg   <= (occ_next == '0) ? '0 :
                          (cmd.upd ? cell_next[0] : cell_val[0]);
            count_reg  <= occ_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {status_reg, found_reg, count_reg, head_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= olsu_pkg::count_t'(N))
        else $error("occupancy beyond capacity");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == olsu_pkg::ST_FULL) |->
            count_reg == olsu_pkg::count_t'(N))
        else $error("full status with a list that is not full");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && found_reg) |-> status_reg == olsu_pkg::ST_OK)
        else $error("found flag with a failing status");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_valid_reg && count_reg == occ_reg))
        else $error("accepted request left no matching result");

endmodule

### rtl/core/olsu_cell.sv
// One storage cell of the ordered list chain.
// Depends on olsu_pkg for the value and command types.
module olsu_cell (
    input  logic                aclk,
    input  olsu_pkg::cell_cmd_t cmd,
    input  logic                valid,      // position lies below the occupancy
    input  olsu_pkg::value_t    left_val,   // neighbor nearer the head
    input  olsu_pkg::value_t    right_val,  // neighbor nearer the tail
    input  logic                hit_in,     // a hit exists nearer the head
    output logic                hit_out,
    output olsu_pkg::value_t    val,
    output olsu_pkg::value_t    val_next
);

    olsu_pkg::value_t val_reg;
    logic             hit;

    always_comb begin
        if (cmd.ins) begin
            hit = !valid || cmd.any || (val_reg > cmd.key);
        end else begin
            hit = valid && (cmd.any || (val_reg == cmd.key));
        end
    end

    assign hit_out = hit_in || hit;

    always_comb begin
        val_next = val_reg;
        if (cmd.ins) begin
            if (hit_in) begin
                val_next = left_val;
            end else if (hit) begin
                val_next = cmd.key;
            end
        end else if (cmd.del && (hit_in || hit)) begin
            val_next = right_val;
        end
    end

    // Entries carry no reset: positions at or above the occupancy are never read.
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

### tb/sv/ordered_list_store_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for ordered_list_store_unit: directed and random list requests,
// each result checked against a behavioral copy of the list. Uses olsu_pkg.
module ordered_list_store_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Same layout as m_tdata: first member lands in the highest bits.
    typedef struct packed {
        olsu_pkg::status_t status;
        logic              found;
        olsu_pkg::count_t  count;
        olsu_pkg::value_t  head;
    } list_result_t;

    // Behavioral list plus the queue of results still owed by the block.
    class list_scoreboard;
        olsu_pkg::value_t cells [olsu_pkg::DEPTH];
        int unsigned      occ;
        list_result_t     expected_q [$];
        int unsigned      mismatches;

        function new();
            occ        = 0;
            mismatches = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        // Shift the tail right by one from pos and load v there.
        function void open_gap(int unsigned pos, olsu_pkg::value_t v);
            for (int i = occ; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = v;
            occ++;
        endfunction

        // Shift the tail left over the entry at pos.
        function void close_gap(int unsigned pos);
            for (int i = pos; i + 1 < occ; i++) cells[i] = cells[i+1];
            occ--;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(olsu_pkg::op_t op, olsu_pkg::value_t v,
                                   olsu_pkg::count_t keep);
            olsu_pkg::status_t st;
            logic              hit;
            int unsigned       pos;
            list_result_t      exp_r;
            st  = olsu_pkg::ST_OK;
            hit = 1'b0;
            case (op)
                olsu_pkg::OP_PUSH_HEAD: begin
                    if (occ >= olsu_pkg::DEPTH) st = olsu_pkg::ST_FULL;
                    else open_gap(0, v);
                end
                olsu_pkg::OP_INSERT: begin
                    if (occ >= olsu_pkg::DEPTH) begin
                        st = olsu_pkg::ST_FULL;
                    end else begin
                        // go past every entry that is not strictly greater
                        pos = 0;
                        while (pos < occ && cells[pos] <= v) pos++;
                        open_gap(pos, v);
                    end
                end
                olsu_pkg::OP_POP_HEAD: begin
                    if (occ == 0) st = olsu_pkg::ST_EMPTY;
                    else close_gap(0);
                end
                olsu_pkg::OP_POP_TAIL: begin
                    if (occ == 0) st = olsu_pkg::ST_EMPTY;
                    else occ--;
                end
                olsu_pkg::OP_REMOVE, olsu_pkg::OP_CONTAINS: begin
                    if (occ == 0) begin
                        st = olsu_pkg::ST_EMPTY;
                    end else begin
                        pos = 0;
                        while (pos < occ && cells[pos] != v) pos++;
                        if (pos < occ) begin
                            hit = 1'b1;
                            if (op == olsu_pkg::OP_REMOVE) close_gap(pos);
                        end else begin
                            st = olsu_pkg::ST_MISSING;
                        end
                    end
                end
                olsu_pkg::OP_CLEAR: occ = 0;
                default: begin
                    if (keep < occ) occ = keep;
                end
            endcase
            exp_r.head   = (occ > 0) ? cells[0] : '0;
            exp_r.count  = olsu_pkg::count_t'(occ);
            exp_r.found  = hit;
            exp_r.status = st;
            expected_q.push_back(exp_r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        // Compare one drained result with the oldest pending one.
        task check_result(logic [15:0] data);
            list_result_t got;
            list_result_t want;
            got = list_result_t'(data);
            if (expected_q.size() == 0) begin
                report_mismatch("unrequested result", data, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.head !== want.head)
                    report_mismatch("head_value", got.head, want.head);
                if (got.count !== want.count)
                    report_mismatch("entry_count", got.count, want.count);
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] value, [12:8] keep_count, [15:13] zero
    logic [2:0]  s_tuser;   // [2:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] head_value, [12:8] entry_count,
                            // [13] found, [15:14] status

    int unsigned    send_idle_pct = 32;
    int unsigned    recv_idle_pct = 75;
    int unsigned    cycle_count   = 0;
    list_scoreboard sb;

    ordered_list_store_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, one decision per falling edge.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result drained at a rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Offer one request; entered and left at a falling edge. Idle first at
    // random, then hold the request until the block takes it.
    task automatic send_request(olsu_pkg::op_t op, olsu_pkg::value_t v,
                                olsu_pkg::count_t keep);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, keep, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, v, keep);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every pending result has drained.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
    endtask

    // Random requests in alternating grow and shrink runs, so the list swings
    // between empty and full; values often repeat or come from the list itself
    // so that remove and contains hit.
    task automatic run_random_phase(int n_items);
        olsu_pkg::op_t    op;
        olsu_pkg::value_t v;
        olsu_pkg::count_t keep;
        int unsigned      r;
        int unsigned      run_left;
        bit               grow;
        grow     = 1'b1;
        run_left = $urandom_range(120, 40);
        for (int n = 0; n < n_items; n++) begin
            if (run_left == 0) begin
                grow     = !grow;
                run_left = $urandom_range(120, 40);
            end
            run_left--;
            r = $urandom_range(99);
            if (grow) begin
                op = (r < 36) ? olsu_pkg::OP_INSERT   :
                     (r < 56) ? olsu_pkg::OP_PUSH_HEAD :
                     (r < 71) ? olsu_pkg::OP_CONTAINS :
                     (r < 81) ? olsu_pkg::OP_REMOVE :
                     (r < 88) ? olsu_pkg::OP_POP_HEAD :
                     (r < 95) ? olsu_pkg::OP_POP_TAIL :
                     (r < 99) ? olsu_pkg::OP_KEEP     : olsu_pkg::OP_CLEAR;
            end else begin
                op = (r < 10) ? olsu_pkg::OP_INSERT   :
                     (r < 18) ? olsu_pkg::OP_PUSH_HEAD :
                     (r < 33) ? olsu_pkg::OP_CONTAINS :
                     (r < 55) ? olsu_pkg::OP_REMOVE :
                     (r < 73) ? olsu_pkg::OP_POP_HEAD :
                     (r < 90) ? olsu_pkg::OP_POP_TAIL :
                     (r < 98) ? olsu_pkg::OP_KEEP     : olsu_pkg::OP_CLEAR;
            end
            case ($urandom_range(3))
                0: v = (sb.occ > 0) ? sb.cells[$urandom_range(sb.occ - 1)]
                                    : olsu_pkg::value_t'($urandom_range(255));
                1: v = olsu_pkg::value_t'($urandom_range(7));
                2: v = olsu_pkg::value_t'(255 - $urandom_range(3));
                default: v = olsu_pkg::value_t'($urandom_range(255));
            endcase
            if (sb.occ > 0 && $urandom_range(1))
                keep = olsu_pkg::count_t'($urandom_range(sb.occ));
            else
                keep = olsu_pkg::count_t'($urandom_range(olsu_pkg::DEPTH));
            send_request(op, v, keep);
            // pause the sender now and then until every pending result has drained
            if (n % 250 == 249) hold_until_drained();
        end
    endtask

    initial begin
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty list: pops report empty, searches report empty, clear and
        // keep first stay ok.
        send_request(olsu_pkg::OP_POP_HEAD, 8'h00, 5'd0);
        send_request(olsu_pkg::OP_POP_TAIL, 8'hFF, 5'd0);
        send_request(olsu_pkg::OP_REMOVE,   8'h00, 5'd0);
        send_request(olsu_pkg::OP_CONTAINS, 8'hFF, 5'd16);
        send_request(olsu_pkg::OP_CLEAR,    8'h00, 5'd0);
        send_request(olsu_pkg::OP_KEEP,     8'h00, 5'd0);
        // Sorted insert at both value extremes, an equal value goes after
        // its twin.
        send_request(olsu_pkg::OP_INSERT,   8'h80, 5'd0);
        send_request(olsu_pkg::OP_INSERT,   8'h00, 5'd0);
        send_request(olsu_pkg::OP_INSERT,   8'hFF, 5'd31);
        send_request(olsu_pkg::OP_INSERT,   8'h80, 5'd0);
        send_request(olsu_pkg::OP_PUSH_HEAD, 8'h55, 5'd0);
        // Searches: hit, miss, remove the first equal entry, remove a miss.
        send_request(olsu_pkg::OP_CONTAINS, 8'h80, 5'd0);
        send_request(olsu_pkg::OP_CONTAINS, 8'h7F, 5'd0);
        send_request(olsu_pkg::OP_REMOVE,   8'h80, 5'd0);
        send_request(olsu_pkg::OP_REMOVE,   8'h11, 5'd0);
        // Keep count at and above occupancy changes nothing; a smaller one drops the tail.
        send_request(olsu_pkg::OP_KEEP,     8'h00, 5'd16);
        send_request(olsu_pkg::OP_KEEP,     8'h00, 5'd4);
        send_request(olsu_pkg::OP_KEEP,     8'hAA, 5'd2);
        send_request(olsu_pkg::OP_POP_TAIL, 8'h00, 5'd0);
        send_request(olsu_pkg::OP_INSERT,   8'h01, 5'd0);
        send_request(olsu_pkg::OP_POP_HEAD, 8'h00, 5'd0);
        send_request(olsu_pkg::OP_CLEAR,    8'h00, 5'd0);
        hold_until_drained();

        run_random_phase(530);
        hold_until_drained();
        send_idle_pct = 75;
        recv_idle_pct = 32;
        run_random_phase(530);
        hold_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(540);
        hold_until_drained();

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/olsu_pkg.sv
rtl/core/olsu_cell.sv
rtl/core/ordered_list_store_unit.sv
tb/sv/ordered_list_store_unit_tb.sv
